### rtl/pdc_pkg.sv
// Types and constants for the PID controller with deadband and clamps.
// No dependencies; imported by the core.
package pdc_pkg;

   // Fraction bits of the Q8.8 gains
   localparam int FRAC_BITS = 8;

   typedef logic signed [15:0] error_type;
   typedef logic signed [15:0] gain_type;
   typedef logic signed [23:0] integ_type;
   typedef logic        [22:0] ilimit_type;
   typedef logic        [14:0] band_type;
   typedef logic        [14:0] olimit_type;
   typedef logic        [2:0]  csr_index_type;
   typedef logic        [22:0] csr_data_type;

   // Register indexes
   localparam csr_index_type CSR_GAIN_P         = 3'd0;
   localparam csr_index_type CSR_GAIN_I         = 3'd1;
   localparam csr_index_type CSR_GAIN_D         = 3'd2;
   localparam csr_index_type CSR_INTEGRAL_LIMIT = 3'd3;
   localparam csr_index_type CSR_DEADBAND       = 3'd4;
   localparam csr_index_type CSR_OUTPUT_LIMIT   = 3'd5;

endpackage

### rtl/pid_controller_deadband_clamp_core.sv
// Positional PID controller core with error deadband, integral clamp and
// output clamp. Depends on pdc_pkg for types, register indexes and FRAC_BITS.
//
// Usage:
//  - req_ channel: one signed error sample per transaction, taken when
//    req_valid is high and req_stall is low.
//  - rsp_ channel: one transaction per sample, carrying the clamped drive
//    value and a flag set when the output limit cut the sum.
//  - csr_ port: write-only; csr_write with csr_index/csr_data sets one
//    register. Any write to a defined register also clears the stored error
//    and the integral. Write only while no transaction is in flight.
//  - Path: a taken sample updates the state registers; multiply/sum/clamp
//    then load the result register once it can load (empty or taken).
//  - Throughput: one sample per cycle while the result is not stalled; the
//    integral and previous-error update is a single add and clamp, so
//    consecutive samples chain back to back.
//  - A stalled result holds in the result register; the update stage keeps
//    accepting until it too is full, then req_stall rises.
//  - Reset (synchronous, active high) clears the configuration registers,
//    the stored error, the integral and both valid flags.
module pid_controller_deadband_clamp_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  pdc_pkg::error_type     req_error_in,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output pdc_pkg::error_type     rsp_drive,
   output logic                   rsp_clamped,
   input  logic                   csr_write,
   input  pdc_pkg::csr_index_type csr_index,
   input  pdc_pkg::csr_data_type  csr_data
);
   import pdc_pkg::*;

   // configuration
   gain_type   gain_p_ff, gain_i_ff, gain_d_ff;
   ilimit_type integral_limit_ff;
   band_type   deadband_ff;
   olimit_type output_limit_ff;
   logic       csr_hit;

   // controller state; also the stage-1 operands for the multipliers
   error_type  prev_error_ff, prev_error_in;
   integ_type  integral_ff, integral_in;
   logic signed [16:0] s1_deriv_ff, s1_deriv_in;
   logic       s1_valid_ff, s1_valid_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   error_type  rsp_drive_ff, rsp_drive_in;
   logic       rsp_clamped_ff, rsp_clamped_in;

   logic       req_accept, advance;

   // stage 1 logic
   logic signed [16:0] err_ext;
   logic        [16:0] err_mag;
   error_type          db_err;
   logic signed [24:0] integ_sum, ilim;
   integ_type          integ_clamped;

   // stage 2 logic
   logic signed [31:0] prod_p, term_p;
   logic signed [39:0] prod_i, term_i;
   logic signed [32:0] prod_d, term_d;
   logic signed [33:0] pid_sum, olim;

   // ---------------------------------------------------------------
   // Handshake: the result register frees up when empty or taken; the
   // update stage moves forward whenever the result register can load.
   // ---------------------------------------------------------------
   assign advance    = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = s1_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   assign csr_hit = csr_write && (csr_index == CSR_GAIN_P || csr_index == CSR_GAIN_I ||
                                  csr_index == CSR_GAIN_D || csr_index == CSR_INTEGRAL_LIMIT ||
                                  csr_index == CSR_DEADBAND || csr_index == CSR_OUTPUT_LIMIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff         <= '0;
         gain_i_ff         <= '0;
         gain_d_ff         <= '0;
         integral_limit_ff <= '0;
         deadband_ff       <= '0;
         output_limit_ff   <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_GAIN_P:         gain_p_ff         <= csr_data[15:0];
            CSR_GAIN_I:         gain_i_ff         <= csr_data[15:0];
            CSR_GAIN_D:         gain_d_ff         <= csr_data[15:0];
            CSR_INTEGRAL_LIMIT: integral_limit_ff <= csr_data;
            CSR_DEADBAND:       deadband_ff       <= csr_data[14:0];
            CSR_OUTPUT_LIMIT:   output_limit_ff   <= csr_data[14:0];
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: deadband, integral update and clamp, derivative.
   // -32768 has magnitude 32768, which always clears any 15-bit deadband.
   // ---------------------------------------------------------------
   always_comb begin
      err_ext  = {req_error_in[15], req_error_in};
      err_mag  = err_ext[16] ? 17'(-err_ext) : 17'(err_ext);
      db_err   = (err_mag < {2'b00, deadband_ff}) ? '0 : req_error_in;

      integ_sum = {integral_ff[23], integral_ff} + {{9{db_err[15]}}, db_err};
      ilim      = $signed({2'b00, integral_limit_ff});
      if (integ_sum > ilim)
         integ_clamped = ilim[23:0];
      else if (integ_sum < -ilim)
         integ_clamped = 24'(-ilim);
      else
         integ_clamped = integ_sum[23:0];

      prev_error_in = prev_error_ff;
      integral_in   = integral_ff;
      s1_deriv_in   = s1_deriv_ff;
      s1_valid_in   = s1_valid_ff && !advance;
      if (csr_hit) begin
         prev_error_in = '0;
         integral_in   = '0;
      end else if (req_accept) begin
         prev_error_in = db_err;
         integral_in   = integ_clamped;
         s1_deriv_in   = {db_err[15], db_err} - {prev_error_ff[15], prev_error_ff};
         s1_valid_in   = 1'b1;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: three products, floor shift, exact sum, output clamp.
   // ---------------------------------------------------------------
   always_comb begin
      prod_p  = gain_p_ff * prev_error_ff;
      prod_i  = gain_i_ff * integral_ff;
      prod_d  = gain_d_ff * s1_deriv_ff;
      term_p  = prod_p >>> FRAC_BITS;
      term_i  = prod_i >>> FRAC_BITS;
      term_d  = prod_d >>> FRAC_BITS;
      pid_sum = 34'(term_p) + 34'(term_i) + 34'(term_d);
      olim    = $signed({19'b0, output_limit_ff});

      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_drive_in   = rsp_drive_ff;
      rsp_clamped_in = rsp_clamped_ff;
      if (advance) begin
         rsp_valid_in = s1_valid_ff;
         if (pid_sum > olim) begin
            rsp_drive_in   = olim[15:0];
            rsp_clamped_in = 1'b1;
         end else if (pid_sum < -olim) begin
            rsp_drive_in   = 16'(-olim);
            rsp_clamped_in = 1'b1;
         end else begin
            rsp_drive_in   = pid_sum[15:0];
            rsp_clamped_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_error_ff <= '0;
         integral_ff   <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         prev_error_ff <= prev_error_in;
         integral_ff   <= integral_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_deriv_ff    <= s1_deriv_in;
      rsp_drive_ff   <= rsp_drive_in;
      rsp_clamped_ff <= rsp_clamped_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_drive   = rsp_drive_ff;
   assign rsp_clamped = rsp_clamped_ff;

`ifndef SYNTHESIS
   // integral never leaves the current clamp window
   a_integral_bound: assert property (@(posedge clock) disable iff (reset)
      ($signed({integral_ff[23], integral_ff}) <= $signed({2'b00, integral_limit_ff})) &&
      ($signed({integral_ff[23], integral_ff}) >= -$signed({2'b00, integral_limit_ff})))
      else $error("integral outside clamp window");

   // a stored nonzero error always cleared the deadband
   a_deadband: assert property (@(posedge clock) disable iff (reset)
      (prev_error_ff != '0) |->
      ((prev_error_ff[15] ? 17'(-$signed({1'b1, prev_error_ff})) : {1'b0, prev_error_ff})
       >= {2'b00, deadband_ff}))
      else $error("stored error inside deadband");

   // register write clears the controller state
   a_csr_clear: assert property (@(posedge clock) disable iff (reset)
      csr_hit |=> (prev_error_ff == '0 && integral_ff == '0))
      else $error("state not cleared by register write");

   // both stages full and output stalled: nothing is dropped
   a_hold_full: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && rsp_stall) |=> (s1_valid_ff && rsp_valid_ff))
      else $error("transaction lost under stall");
`endif

endmodule
